// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL files; alb8_ctrl includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Implication checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/alb8_pkg.sv -----
package alb8_pkg;

    localparam logic [63:0] KEY_HIGH_RESET = 64'd7025075654616863398;
    localparam logic [63:0] KEY_LOW_RESET  = 64'd12391396573757525820;

    typedef enum logic [2:0] {
        ST_KEY_INIT,
        ST_KEY_RUN,
        ST_IDLE,
        ST_ROUND,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic dec;
        logic last;
        logic first;
        logic [3:0] rnd;
    } dp_cmd_t;

    typedef struct packed {
        logic key_start;
        logic key_busy;
    } key_stat_t;

    localparam logic [7:0] FWD_BOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

    localparam logic [7:0] INV_BOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

    function automatic logic [7:0] xt(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

// ----- rtl/alb8_keygen.sv -----
module alb8_keygen #(
    parameter int ROUNDS = 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [127:0]            key,
    input  logic [$clog2(ROUNDS+1)-1:0] rd_row,
    output logic [127:0]            rd_key,
    output logic                    busy
);
    import alb8_pkg::*;

    localparam int NROW = ROUNDS + 1;
    localparam int RW   = $clog2(4 * NROW) - 2;

    // one 128-bit round key per row, one row produced per cycle
    logic [127:0] mem [NROW];
    logic [127:0] prev_reg, prev_next;
    logic [7:0]   rc_reg, rc_next;
    logic [RW-1:0] row_reg, row_next;
    logic          busy_reg, busy_next;
    logic [31:0]   t;
    logic [31:0]   w0, w1, w2, w3;

    always_comb begin
        t  = {FWD_BOX[prev_reg[23:16]], FWD_BOX[prev_reg[15:8]],
              FWD_BOX[prev_reg[7:0]], FWD_BOX[prev_reg[31:24]]} ^ {rc_reg, 24'd0};
        w0 = prev_reg[127:96] ^ t;
        w1 = prev_reg[95:64] ^ w0;
        w2 = prev_reg[63:32] ^ w1;
        w3 = prev_reg[31:0] ^ w2;
        prev_next = prev_reg;
        rc_next   = rc_reg;
        row_next  = row_reg;
        busy_next = busy_reg;
        if (start) begin
            prev_next = key;
            rc_next   = 8'h01;
            row_next  = RW'(1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            prev_next = {w0, w1, w2, w3};
            rc_next   = xt(rc_reg);
            row_next  = row_reg + RW'(1);
            busy_next = (row_reg != RW'(NROW - 1));
        end
    end

    always_ff @(posedge aclk) begin
        if (start)
            mem[0] <= key;
        else if (busy_reg)
            mem[row_reg] <= {w0, w1, w2, w3};
        rd_key <= mem[rd_row];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            row_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            row_reg  <= row_next;
        end
        prev_reg <= prev_next;
        rc_reg   <= rc_next;
    end

    assign busy = busy_reg;
endmodule

// ----- rtl/alb8_datapath.sv -----
module alb8_datapath (
    input  logic                aclk,
    input  alb8_pkg::dp_cmd_t   cmd,
    input  logic [127:0]        blk_in,
    input  logic [127:0]        rkey,
    output logic [127:0]        state_out
);
    import alb8_pkg::*;

    logic [7:0] s    [16];
    logic [7:0] sb   [16];
    logic [7:0] pm   [16];
    logic [7:0] mx   [16];
    logic [7:0] ak   [16];
    logic [7:0] res  [16];
    logic [127:0] st_reg, st_next;

    function automatic logic [7:0] m2(input logic [7:0] x); return xt(x); endfunction
    function automatic logic [7:0] m3(input logic [7:0] x); return xt(x) ^ x; endfunction
    function automatic logic [7:0] m9(input logic [7:0] x);
        return xt(xt(xt(x))) ^ x;
    endfunction
    function automatic logic [7:0] mb(input logic [7:0] x);
        return xt(xt(xt(x))) ^ xt(x) ^ x;
    endfunction
    function automatic logic [7:0] md(input logic [7:0] x);
        return xt(xt(xt(x))) ^ xt(xt(x)) ^ x;
    endfunction
    function automatic logic [7:0] me(input logic [7:0] x);
        return xt(xt(xt(x))) ^ xt(xt(x)) ^ xt(x);
    endfunction

    always_comb begin
        for (int k = 0; k < 16; k++) begin
            s[k]  = st_reg[127-8*k -: 8];
            ak[k] = 8'h00;
        end
        // forward: sbox, then combined column/row permutation
        // t[r][c]=s[(r+c)%4][c]; out[r][c]=t[r][(c+r)%4] = s[(2r+c)%4][(c+r)%4]
        // inverse: out[r][c] = t'[(r-c)%4][c], t'[i][c]=s[i][(c-i)%4]
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                if (!cmd.dec) begin
                    sb[r*4+c] = FWD_BOX[s[r*4+c]];
                end else begin
                    sb[r*4+c] = INV_BOX[s[r*4+c]];
                end
            end
        end
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                if (!cmd.dec)
                    pm[r*4+c] = sb[((2*r+c)%4)*4 + (c+r)%4];
                else
                    pm[r*4+c] = sb[((r+4-c)%4)*4 + (c+8-((r+4-c)%4))%4];
            end
        end
        for (int i = 0; i < 4; i++) begin
            for (int k = 0; k < 4; k++) begin
                mx[i*4+k] = 8'h00;
            end
        end
        for (int k = 0; k < 16; k++) begin
            ak[k] = (cmd.dec ? pm[k] : pm[k]) ^ rkey[127-8*k -: 8];
        end
        // forward mix before key, inverse mix after key
        for (int i = 0; i < 4; i++) begin
            if (!cmd.dec) begin
                mx[i*4+0] = m2(pm[i*4]) ^ m3(pm[i*4+1]) ^ pm[i*4+2] ^ pm[i*4+3];
                mx[i*4+1] = pm[i*4] ^ m2(pm[i*4+1]) ^ m3(pm[i*4+2]) ^ pm[i*4+3];
                mx[i*4+2] = pm[i*4] ^ pm[i*4+1] ^ m2(pm[i*4+2]) ^ m3(pm[i*4+3]);
                mx[i*4+3] = m3(pm[i*4]) ^ pm[i*4+1] ^ pm[i*4+2] ^ m2(pm[i*4+3]);
            end else begin
                mx[i*4+0] = me(ak[i*4]) ^ mb(ak[i*4+1]) ^ md(ak[i*4+2]) ^ m9(ak[i*4+3]);
                mx[i*4+1] = m9(ak[i*4]) ^ me(ak[i*4+1]) ^ mb(ak[i*4+2]) ^ md(ak[i*4+3]);
                mx[i*4+2] = md(ak[i*4]) ^ m9(ak[i*4+1]) ^ me(ak[i*4+2]) ^ mb(ak[i*4+3]);
                mx[i*4+3] = mb(ak[i*4]) ^ md(ak[i*4+1]) ^ m9(ak[i*4+2]) ^ me(ak[i*4+3]);
            end
        end
        for (int k = 0; k < 16; k++) begin
            if (!cmd.dec)
                res[k] = (cmd.last ? pm[k] : mx[k]) ^ rkey[127-8*k -: 8];
            else
                res[k] = cmd.last ? ak[k] : mx[k];
        end
        st_next = st_reg;
        if (cmd.load) begin
            st_next = blk_in;
        end else if (cmd.first) begin
            st_next = st_reg ^ rkey;
        end else if (cmd.step) begin
            for (int k = 0; k < 16; k++)
                st_next[127-8*k -: 8] = res[k];
        end
    end

    always_ff @(posedge aclk) begin
        st_reg <= st_next;
    end

    assign state_out = st_reg;
endmodule

// ----- rtl/alb8_ctrl.sv -----
module alb8_ctrl #(
    parameter int ROUNDS = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_opcode,
    output logic                m_valid,
    input  logic                m_ready,
    input  logic                cfg_hit,
    input  alb8_pkg::key_stat_t kst,
    output alb8_pkg::dp_cmd_t   cmd,
    output logic [$clog2(ROUNDS+1)-1:0] rd_row
);
    import alb8_pkg::*;
    `include "assert_macros.svh"

    localparam int RW = $clog2(4 * (ROUNDS + 1)) - 2;

    ctrl_state_t st_reg, st_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        dec_reg, dec_next;
    logic        acc;
    logic [3:0]  rrow;

    assign acc = s_valid && s_ready;

    // round row read in the cycle before it is used
    always_comb begin
        cnt_next = cnt_reg;
        dec_next = dec_reg;
        if (acc) begin
            cnt_next = 4'd0;
            dec_next = s_opcode;
        end else if (st_reg == ST_ROUND) begin
            cnt_next = cnt_reg + 4'd1;
        end
        rrow = dec_next ? 4'(ROUNDS) - cnt_next : cnt_next;
    end
    assign rd_row = rrow[RW-1:0];

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_KEY_INIT: st_next = ST_KEY_RUN;
            // stay put when a new key write lands as the expansion ends
            ST_KEY_RUN:  if (!kst.key_busy && !cfg_hit) st_next = ST_IDLE;
            ST_IDLE: begin
                if (cfg_hit) st_next = ST_KEY_RUN;
                else if (acc) st_next = ST_ROUND;
            end
            ST_ROUND:    if (cnt_reg == 4'(ROUNDS)) st_next = ST_DONE;
            ST_DONE:     if (m_ready) st_next = ST_IDLE;
            default:     st_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = (st_reg == ST_IDLE) && !cfg_hit;
        m_valid   = (st_reg == ST_DONE);
        cmd.load  = acc;
        cmd.dec   = dec_reg;
        cmd.rnd   = cnt_reg;
        cmd.first = (st_reg == ST_ROUND) && (cnt_reg == 4'd0);
        cmd.step  = (st_reg == ST_ROUND);
        cmd.last  = dec_reg ? (cnt_reg == 4'(ROUNDS)) : (cnt_reg == 4'(ROUNDS));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_KEY_INIT;
        end else begin
            st_reg <= st_next;
        end
        cnt_reg <= cnt_next;
        dec_reg <= dec_next;
    end

    `ASSERT_CLK(a_no_accept_busy, aclk, aresetn, (st_reg != ST_IDLE) |-> !s_ready,
        "input taken outside idle")
    `ASSERT_CLK(a_done_after_round, aclk, aresetn, $rose(m_valid) |-> $past(st_reg == ST_ROUND),
        "result without a final round")
    `ASSERT_CLK(a_key_quiet, aclk, aresetn,
        kst.key_busy |-> (st_reg == ST_KEY_RUN || st_reg == ST_KEY_INIT),
        "key expansion overlaps work")
endmodule

// ----- rtl/aes_like_block_cipher_8round_top.sv -----
// After the input transfer come the first key addition and then one round per cycle
// for ROUNDS rounds; the result is then valid.
// A new block is taken only once the last result has been transferred; a held result stalls
// s_ready until its transfer. One shared round unit reads one round key row per cycle.
// Reset: synchronous, aresetn low; after release the reset key is expanded and s_ready
// rises once the expansion ends. A key write re-expands likewise.
module aes_like_block_cipher_8round_top #(
    parameter int ROUNDS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [63:0] s_block_high,
    input  logic [63:0] s_block_low,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_result_high,
    output logic [63:0] m_result_low,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import alb8_pkg::*;

    localparam int RW = $clog2(4 * (ROUNDS + 1)) - 2;

    logic [63:0]  key_high_reg, key_low_reg;
    logic         cfg_hit, kstart_reg;
    logic [RW-1:0] rd_row;
    logic [127:0] rkey, st;
    key_stat_t    kst;
    dp_cmd_t      cmd;
    logic         kbusy;
    logic         rst_start;

    // take key writes only while idle or as the key expansion ends: the controller holds off inputs meanwhile
    assign cfg_ready = !kbusy && !m_valid && !cmd.step && !rst_start;
    assign cfg_hit   = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= KEY_HIGH_RESET;
            key_low_reg  <= KEY_LOW_RESET;
            kstart_reg   <= 1'b1;
        end else begin
            kstart_reg <= cfg_hit;
            if (cfg_hit && cfg_index == 1'b0) key_high_reg <= cfg_data;
            if (cfg_hit && cfg_index == 1'b1) key_low_reg  <= cfg_data;
        end
    end
    assign rst_start = kstart_reg;

    assign kst.key_start = kstart_reg;
    assign kst.key_busy  = kbusy || kstart_reg;

    alb8_keygen #(.ROUNDS(ROUNDS)) u_key (
        .aclk(aclk), .aresetn(aresetn), .start(kstart_reg),
        .key({key_high_reg, key_low_reg}), .rd_row(rd_row),
        .rd_key(rkey), .busy(kbusy)
    );

    alb8_ctrl #(.ROUNDS(ROUNDS)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_opcode(s_opcode), .m_valid(m_valid), .m_ready(m_ready),
        .cfg_hit(cfg_hit), .kst(kst), .cmd(cmd), .rd_row(rd_row)
    );

    alb8_datapath u_dp (
        .aclk(aclk), .cmd(cmd), .blk_in({s_block_high, s_block_low}),
        .rkey(rkey), .state_out(st)
    );

    assign m_result_high = st[127:64];
    assign m_result_low  = st[63:0];
endmodule
